// File: rtl/core/olr_pkg.sv
// Shared types, widths, codes and reset values for the jet/lepton overlap
// removal block. No dependencies; imported by the top level, olr_cone and the bench.
package olr_pkg;

   localparam int ACT_W      = 2;
   localparam int PT_W       = 14;
   localparam int ETA_W      = 11;
   localparam int PHI_W      = 10;
   localparam int TAG_W      = 16;
   localparam int ENTRY_W    = ETA_W + PHI_W;
   localparam int MAXETA_W   = 10;
   localparam int CONE_W     = 20;
   localparam int CNT_OUT_W  = 5;
   localparam int AETA_W     = ETA_W;
   localparam int DPHI_W     = PHI_W;
   localparam int AETA_SQ_W  = 2 * AETA_W;
   localparam int DPHI_SQ_W  = 2 * DPHI_W;
   localparam int DIST_W     = AETA_SQ_W + 1;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;

   localparam int DEFAULT_MAX_LEPTONS = 16;

   // item kinds carried in req_tuser
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_JET   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_JET_PT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ABS_ETA  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CONE_SQUARED = 2'd2;

   localparam logic [PT_W-1:0]     RESET_MIN_JET_PT   = 14'd120;
   localparam logic [MAXETA_W-1:0] RESET_MAX_ABS_ETA  = 10'd766;
   localparam logic [CONE_W-1:0]   RESET_CONE_SQUARED = 20'd4246;

   // status from the cone unit to the sequencer
   typedef struct packed {
      logic busy;   // an entry is inside the pipe, not yet at the output
      logic valid;  // hit below belongs to one table entry
      logic hit;    // entry lies strictly inside the cone
   } cone_rsp_type;

endpackage

// File: rtl/core/jet_lepton_overlap_removal.sv
// Top level of the jet/lepton overlap removal block: sequencer, registers,
// lepton table. Depends on olr_pkg, olr_ram and olr_cone.
//
// Usage: items enter on req_* (kind in req_tuser: clear table, add lepton,
// test jet). Every item gives exactly one result on rsp_*. Per event, send
// a clear, the leptons, then the jets. Registers on csr_* (always ready) must
// be written only while the block is idle; the block does not enforce this.
// Steps: clear, add and unused kinds go from acceptance to the finish step,
// which loads the result, then back to idle. A jet that passes the pt and eta
// cuts with stored leptons scans the table one entry per cycle through the
// single RAM read port and the three-stage cone unit, then waits until the
// cone unit is empty before the finish step; a jet that fails the cuts or
// meets an empty table goes straight to the finish step.
// One item is in work at a time; the next item is accepted while a result
// still waits in the output register. If the receiver stalls, the block
// finishes its item, then holds it until rsp_tready and accepts nothing more.
// Reset (synchronous, active high) empties the table count, clears the
// overflow flag and the output valid, and restores register defaults.
module jet_lepton_overlap_removal
   import olr_pkg::*;
#(
   parameter int MAX_LEPTONS = DEFAULT_MAX_LEPTONS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // req_tdata from bit 0: pt[14], eta[11], phi[10], jet_tag[16], zero pad[5]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: action[2]
   input  logic [ACT_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // rsp_tdata from bit 0: kept[1], tag_out[16], lepton_count[5], overflow[1],
   // zero pad[1]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = (MAX_LEPTONS > 1) ? $clog2(MAX_LEPTONS) : 1;
   localparam int CW = $clog2(MAX_LEPTONS + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                overflow_ff, overflow_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                hit_ff, hit_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                pass_ff, pass_in;
   logic                is_jet_ff, is_jet_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [PT_W-1:0]     min_jet_pt_ff;
   logic [MAXETA_W-1:0] max_abs_eta_ff;
   logic [CONE_W-1:0]   cone_squared_ff;

   logic [ETA_W-1:0]    eta_ff, eta_in;
   logic [PHI_W-1:0]    phi_ff, phi_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [PT_W-1:0]     req_pt;
   logic [ETA_W-1:0]    req_eta;
   logic [PHI_W-1:0]    req_phi;
   logic [TAG_W-1:0]    req_tag;
   logic [AETA_W-1:0]   req_aeta;
   logic                req_fire;
   logic                cuts_ok;
   logic                table_full;
   logic                wr_en;
   logic                rd_en;
   logic [CW-1:0]       idx_next;
   logic [ENTRY_W-1:0]  rd_entry;
   logic [CW+CNT_OUT_W-1:0] count_wide;
   logic                kept;
   cone_rsp_type        cone_rsp;

   assign req_pt   = req_tdata[PT_W-1:0];
   assign req_eta  = req_tdata[PT_W +: ETA_W];
   assign req_phi  = req_tdata[PT_W+ETA_W +: PHI_W];
   assign req_tag  = req_tdata[PT_W+ETA_W+PHI_W +: TAG_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign req_aeta   = req_eta[ETA_W-1] ? (~req_eta + 1'b1) : req_eta;
   assign cuts_ok    = (req_pt >= min_jet_pt_ff) && (req_aeta <= AETA_W'(max_abs_eta_ff));
   assign table_full = (count_ff >= CW'(MAX_LEPTONS));
   assign wr_en      = req_fire && (req_tuser == ACT_ADD) && !table_full;
   assign rd_en      = (state_ff == S_SCAN);
   assign idx_next   = idx_ff + 1'b1;
   assign count_wide = {{CNT_OUT_W{1'b0}}, count_ff};
   assign kept       = is_jet_ff & pass_ff & ~hit_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff | (cone_rsp.valid & cone_rsp.hit);
      rd_valid_in  = rd_en;
      pass_in      = pass_ff;
      is_jet_in    = is_jet_ff;
      eta_in       = eta_ff;
      phi_in       = phi_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               eta_in    = req_eta;
               phi_in    = req_phi;
               tag_in    = req_tag;
               is_jet_in = (req_tuser == ACT_JET);
               pass_in   = cuts_ok;
               hit_in    = 1'b0;
               idx_in    = '0;
               state_in  = S_DONE;
               case (req_tuser)
                  ACT_CLEAR: begin
                     count_in    = '0;
                     overflow_in = 1'b0;
                  end
                  ACT_ADD: begin
                     if (table_full) begin
                        overflow_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_JET: begin
                     if (cuts_ok && (count_ff != '0)) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            idx_in = idx_next;
            if (idx_next == count_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // wait until the last entry has left the cone unit
            if (!rd_valid_ff && !cone_rsp.busy && !cone_rsp.valid) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, overflow_ff, count_wide[CNT_OUT_W-1:0],
                               is_jet_ff ? tag_ff : {TAG_W{1'b0}}, kept};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         overflow_ff     <= 1'b0;
         idx_ff          <= '0;
         hit_ff          <= 1'b0;
         rd_valid_ff     <= 1'b0;
         pass_ff         <= 1'b0;
         is_jet_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         min_jet_pt_ff   <= RESET_MIN_JET_PT;
         max_abs_eta_ff  <= RESET_MAX_ABS_ETA;
         cone_squared_ff <= RESET_CONE_SQUARED;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         rd_valid_ff  <= rd_valid_in;
         pass_ff      <= pass_in;
         is_jet_ff    <= is_jet_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MIN_JET_PT:   min_jet_pt_ff   <= csr_data[PT_W-1:0];
               REG_MAX_ABS_ETA:  max_abs_eta_ff  <= csr_data[MAXETA_W-1:0];
               REG_CONE_SQUARED: cone_squared_ff <= csr_data[CONE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      eta_ff      <= eta_in;
      phi_ff      <= phi_in;
      tag_ff      <= tag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   olr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_LEPTONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_eta, req_phi}),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   olr_cone u_cone (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (rd_valid_ff),
      .lep_entry    (rd_entry),
      .jet_eta      (eta_ff),
      .jet_phi      (phi_ff),
      .cone_squared (cone_squared_ff),
      .cone_rsp     (cone_rsp)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LEPTONS))
      else $error("lepton count above table depth");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (count_ff == CW'(MAX_LEPTONS)))
      else $error("overflow flag set while table not full");

   a_idle_empty_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!rd_valid_ff && !cone_rsp.busy && !cone_rsp.valid))
      else $error("table read still in flight while idle");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff < count_ff))
      else $error("table read beyond stored entries");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside of the finish step");

endmodule

// File: rtl/core/olr_ram.sv
// Generic single-port-write / single-port-read synchronous RAM with a
// registered read. No dependencies.
module olr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/olr_cone.sv
// Three-stage cone test of one stored lepton against the jet under test:
// |deta| and wrapped |dphi|, then squares, then sum and compare. Uses olr_pkg.
module olr_cone
   import olr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [ENTRY_W-1:0]  lep_entry,
   input  logic [ETA_W-1:0]    jet_eta,
   input  logic [PHI_W-1:0]    jet_phi,
   input  logic [CONE_W-1:0]   cone_squared,
   output cone_rsp_type        cone_rsp
);

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s3_valid_ff, s3_valid_in;
   logic [AETA_W-1:0]    aeta_ff, aeta_in;
   logic [DPHI_W-1:0]    dphi_ff, dphi_in;
   logic [AETA_SQ_W-1:0] aeta_sq_ff, aeta_sq_in;
   logic [DPHI_SQ_W-1:0] dphi_sq_ff, dphi_sq_in;
   logic                 hit_ff, hit_in;

   logic [ETA_W:0]       deta;
   logic [ETA_W:0]       deta_abs;
   logic [PHI_W-1:0]     dphi_raw;
   logic [DIST_W-1:0]    dist_sum;

   always_comb begin
      deta     = {jet_eta[ETA_W-1], jet_eta}
               - {lep_entry[ENTRY_W-1], lep_entry[ENTRY_W-1:PHI_W]};
      deta_abs = deta[ETA_W] ? (~deta + 1'b1) : deta;
      aeta_in  = deta_abs[AETA_W-1:0];
      dphi_raw = jet_phi - lep_entry[PHI_W-1:0];
      // fold the azimuth difference into 0..pi
      dphi_in  = (dphi_raw > PHI_W'(512)) ? (~dphi_raw + 1'b1) : dphi_raw;
      s1_valid_in = in_valid;

      aeta_sq_in  = aeta_ff * aeta_ff;
      dphi_sq_in  = dphi_ff * dphi_ff;
      s2_valid_in = s1_valid_ff;

      dist_sum    = {1'b0, aeta_sq_ff} + DIST_W'(dphi_sq_ff);
      hit_in      = dist_sum < DIST_W'(cone_squared);
      s3_valid_in = s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      aeta_ff    <= aeta_in;
      dphi_ff    <= dphi_in;
      aeta_sq_ff <= aeta_sq_in;
      dphi_sq_ff <= dphi_sq_in;
      hit_ff     <= hit_in;
   end

   assign cone_rsp.busy  = s1_valid_ff | s2_valid_ff;
   assign cone_rsp.valid = s3_valid_ff;
   assign cone_rsp.hit   = hit_ff;

endmodule

// File: bench/olr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for jet_lepton_overlap_removal: watches the item, result and
// register channels, predicts each result and compares it field by field.
// Depends on olr_pkg.
module olr_checker
   import olr_pkg::*;
#(
   parameter int MAX_LEPTONS = DEFAULT_MAX_LEPTONS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [ACT_W-1:0]       req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     pending
);

   localparam int HALF_TURN   = 1 << (PHI_W - 1);
   localparam int FULL_TURN   = 1 << PHI_W;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                 kept;
      logic [TAG_W-1:0]     tag;
      logic [CNT_OUT_W-1:0] count;
      logic                 overflow;
   } cleaning_result_type;

   logic [PT_W-1:0]         min_pt;
   logic [MAXETA_W-1:0]     eta_limit;
   logic [CONE_W-1:0]       cone_sq;
   logic signed [ETA_W-1:0] lepton_eta [MAX_LEPTONS];
   logic [PHI_W-1:0]        lepton_phi [MAX_LEPTONS];
   int                      lepton_total;
   logic                    lepton_lost;
   cleaning_result_type     awaited_results [$];
   int                      bad_count = 0;
   int                      result_index = 0;

   // strict test: a lepton exactly on the cone edge does not match
   function automatic bit lepton_hit(input logic signed [ETA_W-1:0] jet_eta,
                                     input logic [PHI_W-1:0] jet_phi, input int k);
      logic [PHI_W-1:0] phi_diff;
      int               deta;
      int               dphi;
      deta = int'(jet_eta) - int'(lepton_eta[k]);
      if (deta < 0) begin
         deta = -deta;
      end
      phi_diff = jet_phi - lepton_phi[k];
      dphi = int'(phi_diff);
      if (dphi > HALF_TURN) begin
         dphi = FULL_TURN - dphi;
      end
      return deta * deta + dphi * dphi < int'(cone_sq);
   endfunction

   function automatic cleaning_result_type clean_item(input logic [ACT_W-1:0] act,
                                                      input logic [REQ_TDATA_W-1:0] data);
      logic [PT_W-1:0]         pt;
      logic signed [ETA_W-1:0] eta;
      logic [PHI_W-1:0]        phi;
      cleaning_result_type     res;
      int                      abs_eta;
      pt  = data[0 +: PT_W];
      eta = data[PT_W +: ETA_W];
      phi = data[PT_W + ETA_W +: PHI_W];
      res = '0;
      case (act)
         ACT_CLEAR: begin
            lepton_total = 0;
            lepton_lost  = 1'b0;
         end
         ACT_ADD: begin
            if (lepton_total < MAX_LEPTONS) begin
               lepton_eta[lepton_total] = eta;
               lepton_phi[lepton_total] = phi;
               lepton_total++;
            end else begin
               lepton_lost = 1'b1;
            end
         end
         ACT_JET: begin
            res.tag = data[PT_W + ETA_W + PHI_W +: TAG_W];
            abs_eta = (eta < 0) ? -int'(eta) : int'(eta);
            if (pt >= min_pt && abs_eta <= int'(eta_limit)) begin
               res.kept = 1'b1;
               for (int k = 0; k < lepton_total && k < MAX_LEPTONS; k++) begin
                  if (lepton_hit(eta, phi, k)) begin
                     res.kept = 1'b0;
                  end
               end
            end
         end
         default: ;  // unused kind: no state change
      endcase
      res.count    = lepton_total[CNT_OUT_W-1:0];
      res.overflow = lepton_lost;
      return res;
   endfunction

   always @(posedge clock) begin
      cleaning_result_type seen;
      cleaning_result_type want;
      if (reset) begin
         min_pt       = RESET_MIN_JET_PT;
         eta_limit    = RESET_MAX_ABS_ETA;
         cone_sq      = RESET_CONE_SQUARED;
         lepton_total = 0;
         lepton_lost  = 1'b0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MIN_JET_PT:   min_pt    = csr_data[PT_W-1:0];
               REG_MAX_ABS_ETA:  eta_limit = csr_data[MAXETA_W-1:0];
               REG_CONE_SQUARED: cone_sq   = csr_data[CONE_W-1:0];
               default: ;
            endcase
         end
         // retire the result before queuing a new item of the same edge
         if (rsp_tvalid && rsp_tready) begin
            seen.kept     = rsp_tdata[0];
            seen.tag      = rsp_tdata[1 +: TAG_W];
            seen.count    = rsp_tdata[1 + TAG_W +: CNT_OUT_W];
            seen.overflow = rsp_tdata[1 + TAG_W + CNT_OUT_W];
            if (awaited_results.size() == 0) begin
               bad_count++;
               if (bad_count <= MAX_REPORTS) begin
                  $display("result %0d with none expected: kept=%0d tag=%h count=%0d ovf=%0d",
                           result_index, seen.kept, seen.tag, seen.count, seen.overflow);
               end
            end else begin
               want = awaited_results.pop_front();
               if (seen.kept !== want.kept || seen.tag !== want.tag ||
                   seen.count !== want.count || seen.overflow !== want.overflow) begin
                  bad_count++;
                  if (bad_count <= MAX_REPORTS) begin
                     $display("result %0d: expected kept=%0d tag=%h count=%0d ovf=%0d",
                              result_index, want.kept, want.tag, want.count, want.overflow);
                     $display("result %0d: got      kept=%0d tag=%h count=%0d ovf=%0d",
                              result_index, seen.kept, seen.tag, seen.count, seen.overflow);
                  end
               end
            end
            result_index++;
         end
         if (req_tvalid && req_tready) begin
            awaited_results.insert(awaited_results.size(), clean_item(req_tuser, req_tdata));
         end
      end
      mismatches <= bad_count;
      pending    <= awaited_results.size();
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Top of the bench for jet_lepton_overlap_removal: clock, reset, item and register
// stimulus, receiver stalls and the verdict. Depends on olr_pkg and olr_checker.
module tb;
   import olr_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int IDLE_PERCENT  = 15;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_AFTER    = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int ETA_SPAN      = 815;
   localparam int PT_MAX        = (1 << PT_W) - 1;
   localparam int PHI_MAX       = (1 << PHI_W) - 1;
   localparam int TAG_MAX       = (1 << TAG_W) - 1;
   localparam int PAD_W         = REQ_TDATA_W - PT_W - ETA_W - PHI_W - TAG_W;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [ACT_W-1:0]       req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   bit                     steady;
   int                     mismatches;
   int                     pending;

   jet_lepton_overlap_removal i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   olr_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("jet_lepton_overlap_removal: mismatch");
      $finish;
   end

   // receiver: random back-pressure, plus one long hold to fill the block
   initial begin
      int accepted;
      accepted = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (accepted == HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            accepted++;
         end
         rsp_tready <= steady || $urandom_range(0, 99) >= IDLE_PERCENT;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            accepted++;
         end
      end
   end

   function automatic int rand_pt();
      // mostly near the usual thresholds, sometimes anywhere
      if ($urandom_range(0, 9) < 7) begin
         return int'($urandom_range(0, 1000));
      end
      return int'($urandom_range(0, PT_MAX));
   endfunction

   function automatic int rand_eta();
      return int'($urandom_range(0, 2 * ETA_SPAN)) - ETA_SPAN;
   endfunction

   task automatic send_item(input logic [ACT_W-1:0] act, input int pt, input int eta,
                            input int phi, input int tag);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{PAD_W{1'b0}}, TAG_W'(tag), PHI_W'(phi), ETA_W'(eta), PT_W'(pt)};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_cuts(input int pt_min, input int eta_max, input int cone);
      write_reg(REG_MIN_JET_PT, pt_min);
      write_reg(REG_MAX_ABS_ETA, eta_max);
      write_reg(REG_CONE_SQUARED, cone);
      csr_valid <= 1'b0;
   endtask

   // drop valid, then hold until every result is back and the block settles
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // events: clear, leptons, then jets, half aimed near a lepton; or a lone random item
   task automatic run_events(input int n_items);
      int ev_eta [20];
      int ev_phi [20];
      int sent;
      int n_lep;
      int n_jet;
      int j;
      int e;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 85) begin
            send_item(ACT_CLEAR, rand_pt(), rand_eta(), $urandom_range(0, PHI_MAX),
                      $urandom_range(0, TAG_MAX));
            n_lep = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 19) : $urandom_range(0, 5);
            for (int k = 0; k < n_lep; k++) begin
               ev_eta[k] = rand_eta();
               ev_phi[k] = $urandom_range(0, PHI_MAX);
               send_item(ACT_ADD, rand_pt(), ev_eta[k], ev_phi[k], $urandom_range(0, TAG_MAX));
            end
            n_jet = $urandom_range(1, 4);
            for (int k = 0; k < n_jet; k++) begin
               if (n_lep > 0 && $urandom_range(0, 1) == 1) begin
                  j = $urandom_range(0, n_lep - 1);
                  e = ev_eta[j] + int'($urandom_range(0, 140)) - 70;
                  if (e > ETA_SPAN) begin
                     e = ETA_SPAN;
                  end
                  if (e < -ETA_SPAN) begin
                     e = -ETA_SPAN;
                  end
                  // phi offset wraps when packed into 10 bits
                  send_item(ACT_JET, rand_pt(), e,
                            ev_phi[j] + int'($urandom_range(0, 140)) - 70,
                            $urandom_range(0, TAG_MAX));
               end else begin
                  send_item(ACT_JET, rand_pt(), rand_eta(), $urandom_range(0, PHI_MAX),
                            $urandom_range(0, TAG_MAX));
               end
            end
            sent += 1 + n_lep + n_jet;
         end else begin
            send_item(ACT_W'($urandom_range(0, 3)), rand_pt(), rand_eta(),
                      $urandom_range(0, PHI_MAX), $urandom_range(0, TAG_MAX));
            sent++;
         end
      end
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_CLEAR;
      csr_valid  = 1'b0;
      csr_index  = REG_MIN_JET_PT;
      csr_data   = '0;
      steady     = 1'b0;
      reset      = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cut edges on an empty table, at the reset settings
      send_item(ACT_CLEAR, 0, 0, 0, 0);
      send_item(ACT_JET, 120, 0, 0, TAG_MAX);
      send_item(ACT_JET, 119, 0, 0, 1);
      send_item(ACT_JET, PT_MAX, 766, PHI_MAX, 2);
      send_item(ACT_JET, PT_MAX, -767, 0, 3);
      send_item(ACT_JET, 500, ETA_SPAN, 0, 4);
      send_item(ACT_JET, 500, -ETA_SPAN, 0, 5);
      // leptons at the eta span ends and the phi extremes, and one at half a turn
      send_item(ACT_ADD, PT_MAX, -ETA_SPAN, 0, TAG_MAX);
      send_item(ACT_ADD, 0, ETA_SPAN, PHI_MAX, 0);
      send_item(ACT_ADD, 0, 0, 512, 0);
      send_item(ACT_JET, 200, 0, 577, 6);
      send_item(ACT_JET, 200, 0, 578, 7);
      // phi difference across the wrap, and exactly half a turn
      send_item(ACT_JET, 500, -766, 1000, 8);
      send_item(ACT_JET, 500, 700, 0, 9);
      send_item(ACT_JET, 500, 0, 0, 10);
      send_item(ACT_UNUSED, PT_MAX, -1, PHI_MAX, TAG_MAX);
      send_item(ACT_CLEAR, PT_MAX, -1, PHI_MAX, TAG_MAX);
      send_item(ACT_JET, 200, 0, 512, 11);
      wait_idle();

      // a lepton exactly on the cone edge is not a match
      set_cuts(int'(RESET_MIN_JET_PT), int'(RESET_MAX_ABS_ETA), 4225);
      send_item(ACT_CLEAR, 0, 0, 0, 0);
      send_item(ACT_ADD, 0, 0, 512, 0);
      send_item(ACT_JET, 200, 0, 577, 12);
      run_events(40);
      wait_idle();

      set_cuts(0, ETA_SPAN, (1 << CONE_W) - 1);
      run_events(40);
      wait_idle();

      set_cuts(PT_MAX, 0, 0);
      run_events(30);
      wait_idle();

      set_cuts(int'(RESET_MIN_JET_PT), int'(RESET_MAX_ABS_ETA), int'(RESET_CONE_SQUARED));
      run_events(220);
      wait_idle();

      steady = 1'b1;
      set_cuts(60, 700, 3000);
      run_events(120);
      wait_idle();
      steady = 1'b0;

      if (mismatches == 0 && pending == 0) begin
         $display("jet_lepton_overlap_removal: match");
      end else begin
         $display("jet_lepton_overlap_removal: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/olr_pkg.sv
rtl/core/olr_ram.sv
rtl/core/olr_cone.sv
rtl/core/jet_lepton_overlap_removal.sv
bench/olr_checker.sv
bench/tb.sv
